// ----- hw/rtl/ldd_pkg.sv -----
// ----------------------------------------------------------------------------
// ldd_pkg: shared types and constants of the light dip detector
// Item and result layouts, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldd_pkg;

  localparam int SAMPLE_BITS           = 12;
  localparam int WEIGHT_FRAC_BITS      = 16;
  localparam int WEIGHT_BITS           = WEIGHT_FRAC_BITS + 1;
  localparam int ACC_BITS              = SAMPLE_BITS + WEIGHT_FRAC_BITS;
  localparam int INDEX_BITS            = 10;
  localparam int LENGTH_BITS           = 11;
  localparam int COUNT_OUT_BITS        = 11;
  localparam int COUNTER_BITS          = 32;
  localparam int HISTORY_DEPTH_DEFAULT = 1024;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int S_TDATA_BITS = ((SAMPLE_BITS + INDEX_BITS + 7) / 8) * 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_WEIGHT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIP_THRESHOLD    = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_MARGIN   = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_HISTORY_LENGTH   = CFG_INDEX_BITS'(3);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE      = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET    = WEIGHT_BITS'(655);
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(228);
  localparam logic [SAMPLE_BITS-1:0] MARGIN_RESET    = SAMPLE_BITS'(68);
  localparam int                     LENGTH_RESET    = 1024;

  typedef enum logic {
    OP_SAMPLE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]  index;
  } item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [SAMPLE_BITS-1:0] threshold;
    logic [SAMPLE_BITS-1:0] margin;
  } cfg_t;

  // Declared from the highest field down, so smoothed_level sits in bit 0.
  typedef struct packed {
    logic                      history_valid;
    logic [SAMPLE_BITS-1:0]    history_value;
    logic [COUNT_OUT_BITS-1:0] samples_held;
    logic [COUNTER_BITS-1:0]   samples_seen;
    logic [COUNT_OUT_BITS-1:0] dips_in_window;
    logic [COUNTER_BITS-1:0]   dips_total;
    logic                      dip_finished;
    logic                      dip_active;
    logic [SAMPLE_BITS-1:0]    smoothed_level;
  } result_t;

  localparam int RESULT_BITS  = $bits(result_t);
  localparam int M_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

// ----- hw/rtl/ldd_front.sv -----
// ----------------------------------------------------------------------------
// ldd_front: input stage
// Takes input requests, decodes their kind and hands them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldd_front import ldd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [S_TDATA_BITS-1:0] s_tdata,
  input  logic                    s_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  logic  held;
  item_t item;

  // Nothing is taken while reset is held, since reset would drop it.
  assign q_push   = held && !q_full;
  assign s_tready = !rst && (!held || !q_full);
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.op     <= s_tuser ? OP_READ : OP_SAMPLE;
      item.sample <= s_tdata[SAMPLE_BITS-1:0];
      item.index  <= s_tdata[SAMPLE_BITS +: INDEX_BITS];
    end
  end

endmodule

// ----- hw/rtl/ldd_queue.sv -----
// ----------------------------------------------------------------------------
// ldd_queue: short request queue
// Small FIFO between the input stage and the processing pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldd_queue import ldd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/ldd_back.sv -----
// ----------------------------------------------------------------------------
// ldd_back: processing pipeline
// Average update, history ring, dip tracking and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldd_back import ldd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT,
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic [CW-1:0] length,
  input  logic          restart,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output result_t       m_result
);

  localparam int PW = ACC_BITS + WEIGHT_BITS + 2;

  // Ring and average state, updated when a sample request leaves the queue.
  logic [ACC_BITS-1:0]     acc;
  logic                    seeded;
  logic [AW-1:0]           write_slot;
  logic [CW-1:0]           held_count;
  logic [COUNTER_BITS-1:0] sample_counter;

  logic [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];
  logic                   mark_mem [HISTORY_DEPTH];

  // Stage A registers.
  logic                   a_valid;
  op_t                    a_op;
  logic [SAMPLE_BITS-1:0] a_x;
  logic [AW-1:0]          a_slot;
  logic                   a_full;
  logic                   a_mark;
  logic [SAMPLE_BITS-1:0] a_hval;
  logic                   a_hvalid;

  // Dip state.
  logic                    in_dip;
  logic [COUNTER_BITS-1:0] dip_counter;
  logic [CW-1:0]           window_count;

  logic                    adv;
  logic                    pop_sample;
  logic                    b_sample;
  logic [ACC_BITS-1:0]     target;
  logic signed [ACC_BITS:0] diff;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    step;
  logic [ACC_BITS-1:0]     acc_upd;
  logic [AW-1:0]           slot_next;
  logic [SAMPLE_BITS:0]    start_level;
  logic [SAMPLE_BITS:0]    release_level;
  logic                    below_start;
  logic                    above_release;
  logic                    dip_seen;
  logic                    fin;
  logic                    in_dip_next;
  logic [CW-1:0]           window_next;
  logic                    fwd_hit;

  assign adv        = !m_tvalid || m_tready;
  assign q_pop      = adv && q_valid;
  assign pop_sample = q_pop && (q_item.op == OP_SAMPLE);
  assign b_sample   = adv && a_valid && (a_op == OP_SAMPLE);

  always_comb begin
    target  = {q_item.sample, {WEIGHT_FRAC_BITS{1'b0}}};
    diff    = $signed({1'b0, target}) - $signed({1'b0, acc});
    prod    = PW'(diff) * PW'($signed({1'b0, cfg.weight}));
    step    = prod >>> WEIGHT_FRAC_BITS;
    acc_upd = acc + step[ACC_BITS-1:0];
  end

  always_comb begin
    if (CW'(write_slot) + CW'(1) >= length) begin
      slot_next = '0;
    end else begin
      slot_next = write_slot + 1'b1;
    end
  end

  // Both dip tests use the average after this sample's update, which is acc.
  always_comb begin
    start_level   = {1'b0, a_x} + {1'b0, cfg.threshold};
    release_level = {1'b0, a_x} + {1'b0, cfg.margin};
    below_start   = {start_level, {WEIGHT_FRAC_BITS{1'b0}}} < {1'b0, acc};
    above_release = {release_level, {WEIGHT_FRAC_BITS{1'b0}}} >= {1'b0, acc};
    dip_seen      = in_dip || below_start;
    fin           = dip_seen && above_release;
    in_dip_next   = dip_seen && !above_release;
    window_next   = window_count - CW'(a_full && a_mark) + CW'(fin);
    fwd_hit       = b_sample && (a_slot == write_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc            <= '0;
      seeded         <= 1'b0;
      write_slot     <= '0;
      held_count     <= '0;
      sample_counter <= '0;
      a_valid        <= 1'b0;
      in_dip         <= 1'b0;
      dip_counter    <= '0;
      window_count   <= '0;
      m_tvalid       <= 1'b0;
    end else if (restart) begin
      write_slot   <= '0;
      held_count   <= '0;
      window_count <= '0;
    end else begin
      if (pop_sample) begin
        acc            <= seeded ? acc_upd : target;
        seeded         <= 1'b1;
        write_slot     <= slot_next;
        sample_counter <= sample_counter + 1'b1;
        if (held_count < length) begin
          held_count <= held_count + 1'b1;
        end
      end
      if (adv) begin
        a_valid  <= q_valid;
        m_tvalid <= a_valid;
      end
      if (b_sample) begin
        in_dip       <= in_dip_next;
        dip_counter  <= dip_counter + COUNTER_BITS'(fin);
        window_count <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op   <= q_item.op;
      a_x    <= q_item.sample;
      a_slot <= write_slot;
      a_full <= (held_count >= length);
      if (q_item.op == OP_SAMPLE) begin
        hist_mem[write_slot] <= q_item.sample;
      end else begin
        a_hval <= hist_mem[AW'(q_item.index)];
      end
      a_hvalid <= (32'(q_item.index) < 32'(held_count));
      a_mark   <= fwd_hit ? fin : mark_mem[write_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (b_sample) begin
      mark_mem[a_slot] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      m_result.smoothed_level <= acc[ACC_BITS-1:WEIGHT_FRAC_BITS];
      m_result.samples_seen   <= sample_counter;
      m_result.samples_held   <= COUNT_OUT_BITS'(held_count);
      if (a_op == OP_SAMPLE) begin
        m_result.dip_active     <= in_dip_next;
        m_result.dip_finished   <= fin;
        m_result.dips_total     <= dip_counter + COUNTER_BITS'(fin);
        m_result.dips_in_window <= COUNT_OUT_BITS'(window_next);
        m_result.history_value  <= '0;
        m_result.history_valid  <= 1'b0;
      end else begin
        m_result.dip_active     <= in_dip;
        m_result.dip_finished   <= 1'b0;
        m_result.dips_total     <= dip_counter;
        m_result.dips_in_window <= COUNT_OUT_BITS'(window_count);
        m_result.history_value  <= a_hvalid ? a_hval : '0;
        m_result.history_valid  <= a_hvalid;
      end
    end
  end

endmodule

// ----- hw/rtl/light_dip_detector_top.sv -----
// ----------------------------------------------------------------------------
// light_dip_detector_top: exponential-average light dip detector
// A request passes the front register, the queue, stage A and the result
// register. Throughput: one request per cycle while results are taken, set
// by the average loop (one multiply) and the single history memory port.
// Reset: synchronous; both ready outputs stay low while it is held, and
// history and dip marks need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module light_dip_detector_top import ldd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // Request stream.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_TDATA_BITS-1:0]   s_tdata,   // light_sample, read_index
  input  logic                      s_tuser,   // kind
  // Result stream.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_TDATA_BITS-1:0]   m_tdata,   // smoothed_level, dip_active,
                                               // dip_finished, dips_total,
                                               // dips_in_window, samples_seen,
                                               // samples_held, history_value,
                                               // history_valid
  // Register writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LENGTH_AT_RESET = (LENGTH_RESET > HISTORY_DEPTH) ? HISTORY_DEPTH
                                                                  : LENGTH_RESET;

  // The register bank. The weight is held already clamped to one, and the
  // history length already forced into the range one to the ring depth, so
  // the pipeline only ever sees usable values.
  cfg_t                   cfg;
  logic [CW-1:0]          length;
  logic                   cfg_write;
  logic                   restart;
  logic [WEIGHT_BITS-1:0] weight_req;
  logic [LENGTH_BITS-1:0] length_req;
  logic [CW-1:0]          length_new;

  logic    q_full;
  logic    q_push;
  item_t   push_item;
  logic    q_pop;
  logic    q_valid;
  item_t   head;
  result_t result;

  // Register writes are refused while reset is held, as reset would lose them.
  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  // Writing the history length starts the ring afresh: the pipeline clears
  // its slot pointer, fill count and windowed dip count in the same cycle.
  assign restart = cfg_write && (cfg_index == REG_HISTORY_LENGTH);

  always_comb begin
    weight_req = cfg_data[WEIGHT_BITS-1:0];
    length_req = cfg_data[LENGTH_BITS-1:0];
    if (length_req == '0) begin
      length_new = CW'(1);
    end else if (32'(length_req) > 32'(HISTORY_DEPTH)) begin
      length_new = CW'(HISTORY_DEPTH);
    end else begin
      length_new = CW'(length_req);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight    <= WEIGHT_RESET;
      cfg.threshold <= THRESHOLD_RESET;
      cfg.margin    <= MARGIN_RESET;
      length        <= CW'(LENGTH_AT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SMOOTHING_WEIGHT: begin
          cfg.weight <= (weight_req > WEIGHT_ONE) ? WEIGHT_ONE : weight_req;
        end
        REG_DIP_THRESHOLD: begin
          cfg.threshold <= cfg_data[SAMPLE_BITS-1:0];
        end
        REG_RELEASE_MARGIN: begin
          cfg.margin <= cfg_data[SAMPLE_BITS-1:0];
        end
        REG_HISTORY_LENGTH: begin
          length <= length_new;
        end
        default: begin
        end
      endcase
    end
  end

  // Front: registers each accepted request and tags it as a sample or a
  // history read. It keeps taking requests as long as the queue has room.
  ldd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // The queue lets the front keep accepting while the result side stalls.
  ldd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head)
  );

  // Back: the first stage updates the average and the ring, the second
  // tracks the dip and fills the result register. Entries of the history
  // and mark memories are only trusted below the fill count, which is why
  // reset leaves their contents alone.
  ldd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .length   (length),
    .restart  (restart),
    .q_valid  (q_valid),
    .q_item   (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  assign m_tdata = M_TDATA_BITS'(result);

endmodule

// ----- hw/rtl/ldd_checker.sv -----
// ----------------------------------------------------------------------------
// ldd_checker: port-level checks of the light dip detector
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldd_checker import ldd_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [M_TDATA_BITS-1:0] m_tdata
);

  result_t res;

  assign res = m_tdata[RESULT_BITS-1:0];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_finish_leaves_dip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.dip_finished |-> !res.dip_active)
    else $error("dip finished but still active");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.dips_in_window <= res.samples_held)
    else $error("windowed dip count above held samples");

  a_invalid_read_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.history_valid |-> res.history_value == '0)
    else $error("invalid history read returned data");

endmodule

bind light_dip_detector_top ldd_checker u_ldd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the light dip detector
// Drives light samples and history reads into the request stream and
// predicts every result with its own model of the smoothed level, the dip
// state machine, the history ring and the windowed dip count. Each result
// is checked field by field. The run has a directed part for the extremes
// and special cases, then random traffic in three idling regimes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ldd_pkg::*;

  // Ring size of the block as built, and bench timing.
  localparam int RING_DEPTH    = HISTORY_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 8;      // a margin beyond the pipeline latency
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int CYCLE_LIMIT   = 200000; // many times the slowest correct run

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs. Every input has a known value from time 0.
  // --------------------------------------------------------------------------
  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata   = '0;  // light_sample, read_index
  logic                      s_tuser   = 1'b0; // kind
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [M_TDATA_BITS-1:0]   m_tdata;          // smoothed_level, dip_active,
                                               // dip_finished, dips_total,
                                               // dips_in_window, samples_seen,
                                               // samples_held, history_value,
                                               // history_valid
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  light_dip_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench-side copy of the detector state and registers. All of it starts
  // at the block's reset values.
  // --------------------------------------------------------------------------
  logic [WEIGHT_BITS-1:0] weight_reg    = WEIGHT_RESET;
  logic [SAMPLE_BITS-1:0] threshold_reg = THRESHOLD_RESET;
  logic [SAMPLE_BITS-1:0] margin_reg    = MARGIN_RESET;
  logic [LENGTH_BITS-1:0] length_reg    = LENGTH_BITS'(LENGTH_RESET);

  longint unsigned        level_acc     = 0;   // average scaled by 2^16
  bit                     primed        = 1'b0;
  bit                     dipping       = 1'b0;
  int                     next_slot     = 0;
  int                     held          = 0;
  int                     window_dips   = 0;
  bit [COUNTER_BITS-1:0]  sample_total  = '0;
  bit [COUNTER_BITS-1:0]  dip_total     = '0;
  logic [SAMPLE_BITS-1:0] stored_samples [RING_DEPTH];
  bit                     dip_flags      [RING_DEPTH];
  // Slots 0 .. written_span-1 have been written since reset; reads never go
  // beyond them, so no never-written entry is ever fetched.
  int                     written_span  = 0;

  // Results predicted for accepted requests, oldest first.
  result_t                pending_readouts [$];
  int                     mismatches    = 0;

  // Traffic shaping, written only by the test sequence.
  int                     tx_idle_pct   = 0;
  int                     rx_idle_pct   = 0;
  int unsigned            hold_token    = 0;
  int                     dip_burst_left = 0;

  // Hold-off state, written only by the receiver, and the watchdog's cycle count.
  int unsigned            hold_seen     = 0;
  int                     hold_left     = 0;
  int                     cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Predictor: works out the result of one accepted request and advances
  // the bench copy of the state exactly as the block should.
  // --------------------------------------------------------------------------
  function automatic result_t predict_readout(input item_t req);
    result_t         res;
    int              ring_len;
    int              slot;
    bit              ended;
    longint unsigned x;
    longint unsigned target;

    res   = '0;
    ended = 1'b0;
    if (req.op == OP_READ) begin
      // Reads only report slots that belong to the current ring contents.
      if (int'(req.index) < held) begin
        res.history_valid = 1'b1;
        res.history_value = stored_samples[req.index];
      end
    end else begin
      x        = req.sample;
      // A length of zero behaves as one, anything past the ring as the ring.
      ring_len = (length_reg == 0) ? 1 :
                 (int'(length_reg) > RING_DEPTH) ? RING_DEPTH : int'(length_reg);
      slot     = (next_slot < ring_len) ? next_slot : 0;
      target   = x << WEIGHT_FRAC_BITS;

      // The first sample seeds the average; a weight of one or more
      // snaps it to the sample. Otherwise the step is floored.
      if (!primed) begin
        level_acc = target;
        primed    = 1'b1;
      end else if (weight_reg >= WEIGHT_ONE) begin
        level_acc = target;
      end else if (target >= level_acc) begin
        level_acc += ((target - level_acc) * weight_reg) >> WEIGHT_FRAC_BITS;
      end else begin
        level_acc -= ((level_acc - target) * weight_reg + (WEIGHT_ONE - 1))
                     >> WEIGHT_FRAC_BITS;
      end
      sample_total++;

      // Start and release tests use the updated average at full precision,
      // so one sample may open and close a dip when the margin is wider.
      if (!dipping && (((x + threshold_reg) << WEIGHT_FRAC_BITS) < level_acc))
        dipping = 1'b1;
      if (dipping && (((x + margin_reg) << WEIGHT_FRAC_BITS) >= level_acc)) begin
        dipping = 1'b0;
        ended   = 1'b1;
        dip_total++;
      end

      stored_samples[slot] = req.sample;
      window_dips          = window_dips - int'(dip_flags[slot]) + int'(ended);
      dip_flags[slot]      = ended;
      next_slot            = (slot + 1 >= ring_len) ? 0 : slot + 1;
      if (held < ring_len)
        held++;
      if (slot + 1 > written_span)
        written_span = slot + 1;
    end

    res.smoothed_level = SAMPLE_BITS'(level_acc >> WEIGHT_FRAC_BITS);
    res.dip_active     = dipping;
    res.dip_finished   = ended;
    res.dips_total     = dip_total;
    res.dips_in_window = COUNT_OUT_BITS'(window_dips);
    res.samples_seen   = sample_total;
    res.samples_held   = COUNT_OUT_BITS'(held);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = result_t'(m_tdata[RESULT_BITS-1:0]);
      if (pending_readouts.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_readouts.pop_front();
        check_field("smoothed_level", want.smoothed_level, got.smoothed_level);
        check_field("dip_active",     want.dip_active,     got.dip_active);
        check_field("dip_finished",   want.dip_finished,   got.dip_finished);
        check_field("dips_total",     want.dips_total,     got.dips_total);
        check_field("dips_in_window", want.dips_in_window, got.dips_in_window);
        check_field("samples_seen",   want.samples_seen,   got.samples_seen);
        check_field("samples_held",   want.samples_held,   got.samples_held);
        check_field("history_value",  want.history_value,  got.history_value);
        check_field("history_valid",  want.history_valid,  got.history_valid);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls at random at the current idle rate, or for a long
  // stretch whenever the test sequence asks for a hold-off.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. It starts at a falling edge, so the valid of a request
  // that was just accepted is either kept high for this one or lowered for
  // an idle gap, never both in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [SAMPLE_BITS-1:0] smp,
                              input logic [INDEX_BITS-1:0] idx);
    item_t req;
    req = '{op: op, sample: smp, index: idx};
    @(negedge clk);
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_TDATA_BITS'({idx, smp});
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_readouts.push_back(predict_readout(req));
  endtask

  // Lowers the request valid and waits until every predicted result has come
  // back, then lets the pipeline settle.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_readouts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SMOOTHING_WEIGHT: weight_reg    = val[WEIGHT_BITS-1:0];
      REG_DIP_THRESHOLD:    threshold_reg = val[SAMPLE_BITS-1:0];
      REG_RELEASE_MARGIN:   margin_reg    = val[SAMPLE_BITS-1:0];
      REG_HISTORY_LENGTH: begin
        // A new length restarts the ring and forgets all dip marks.
        length_reg  = val[LENGTH_BITS-1:0];
        next_slot   = 0;
        held        = 0;
        window_dips = 0;
        foreach (dip_flags[i])
          dip_flags[i] = 1'b0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
    if (v < 0)
      return '0;
    if (v > 4095)
      return SAMPLE_BITS'(4095);
    return SAMPLE_BITS'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Random request source. Most traffic follows the average with dips of a
  // few samples below the start level and recoveries around the release
  // level; the rest is full-range noise and history reads.
  // --------------------------------------------------------------------------
  task automatic next_random_request(output op_t op, output logic [SAMPLE_BITS-1:0] smp,
                                     output logic [INDEX_BITS-1:0] idx);
    int level;
    int roll;
    level = int'(level_acc >> WEIGHT_FRAC_BITS);
    roll  = int'($urandom_range(0, 99));
    op    = OP_SAMPLE;
    smp   = SAMPLE_BITS'($urandom_range(0, 4095));
    idx   = INDEX_BITS'($urandom_range(0, 1023));
    if (roll < 15 && written_span > 0) begin
      op = OP_READ;
      if (held > 0 && $urandom_range(0, 3) != 0)
        idx = INDEX_BITS'($urandom_range(0, held - 1));
      else
        idx = INDEX_BITS'($urandom_range(0, written_span - 1));
    end else if (roll < 23) begin
      // Noise: smp already holds a full-range value.
    end else if (dip_burst_left > 0 || roll < 31) begin
      if (dip_burst_left == 0)
        dip_burst_left = int'($urandom_range(1, 6));
      dip_burst_left--;
      smp = clamp_sample(level - int'(threshold_reg) - int'($urandom_range(1, 200)));
    end else if (roll[0]) begin
      smp = clamp_sample(level - int'(margin_reg) + int'($urandom_range(0, 40)) - 20);
    end else begin
      smp = clamp_sample(level + int'($urandom_range(0, 60)) - 30);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // Seeding, a dip that opens and closes, sample extremes and reads at the
  // reset configuration.
  task automatic test_seed_and_dip();
    send_request(OP_SAMPLE, 12'd2000, 10'd1023);
    send_request(OP_READ,   12'hFFF,  10'd0);
    send_request(OP_SAMPLE, 12'd2000, 10'd0);
    send_request(OP_SAMPLE, 12'd1700, 10'd0);
    send_request(OP_SAMPLE, 12'd2000, 10'd0);
    send_request(OP_SAMPLE, 12'd0,    10'd0);
    send_request(OP_SAMPLE, 12'd4095, 10'd0);
    send_request(OP_READ,   12'd0,    10'd5);
    wait_for_results();
  endtask

  // A frozen average, a weight of exactly one and a weight above one.
  task automatic test_weight_extremes();
    write_register(REG_SMOOTHING_WEIGHT, 32'd0);
    send_request(OP_SAMPLE, 12'd4095, 10'd0);
    write_register(REG_SMOOTHING_WEIGHT, 32'd65536);
    send_request(OP_SAMPLE, 12'd0, 10'd0);
    write_register(REG_SMOOTHING_WEIGHT, 32'd131071);
    send_request(OP_SAMPLE, 12'd3000, 10'd0);
    wait_for_results();
  endtask

  // With the average frozen at 3000: a margin wider than the threshold lets
  // one sample open and close a dip; then both bounds at their extremes.
  task automatic test_threshold_and_margin();
    write_register(REG_SMOOTHING_WEIGHT, 32'd0);
    write_register(REG_DIP_THRESHOLD, 32'd10);
    write_register(REG_RELEASE_MARGIN, 32'd500);
    send_request(OP_SAMPLE, 12'd2900, 10'd0);
    write_register(REG_DIP_THRESHOLD, 32'd4095);
    write_register(REG_RELEASE_MARGIN, 32'd0);
    send_request(OP_SAMPLE, 12'd0, 10'd0);
    write_register(REG_DIP_THRESHOLD, 32'd0);
    send_request(OP_SAMPLE, 12'd2999, 10'd0);
    send_request(OP_SAMPLE, 12'd3000, 10'd0);
    wait_for_results();
  endtask

  // Ring lengths of zero, beyond the ring, and two, with a dip mark being
  // overwritten so the windowed count falls again.
  task automatic test_history_length();
    write_register(REG_HISTORY_LENGTH, 32'd0);
    send_request(OP_SAMPLE, 12'd100, 10'd0);
    send_request(OP_SAMPLE, 12'd300, 10'd0);
    send_request(OP_READ,   12'd0,   10'd0);
    send_request(OP_READ,   12'd0,   10'd1);
    write_register(REG_HISTORY_LENGTH, 32'd2047);
    send_request(OP_SAMPLE, 12'd4095, 10'd0);
    send_request(OP_READ,   12'd0,    10'd0);
    write_register(REG_HISTORY_LENGTH, 32'd2);
    send_request(OP_SAMPLE, 12'd2999, 10'd0);
    send_request(OP_SAMPLE, 12'd3000, 10'd0);
    send_request(OP_SAMPLE, 12'd3000, 10'd0);
    send_request(OP_SAMPLE, 12'd3000, 10'd0);
    send_request(OP_READ,   12'd0,    10'd1);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering requests, so the block fills up and stalls its input.
  task automatic test_backpressure();
    int saved_pct;
    op_t op;
    logic [SAMPLE_BITS-1:0] smp;
    logic [INDEX_BITS-1:0] idx;
    saved_pct   = tx_idle_pct;
    tx_idle_pct = 0;
    hold_token++;
    repeat (40) begin
      next_random_request(op, smp, idx);
      send_request(op, smp, idx);
    end
    wait_for_results();
    tx_idle_pct = saved_pct;
  endtask

  // One random phase: fresh register settings, then random traffic with a
  // pause halfway through until every result is back. The long-ring phase
  // keeps the full ring length.
  task automatic test_random_phase(input int count, input bit long_ring);
    op_t op;
    logic [SAMPLE_BITS-1:0] smp;
    logic [INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0] weight;
    logic [CFG_DATA_BITS-1:0] threshold;
    logic [CFG_DATA_BITS-1:0] margin;
    logic [CFG_DATA_BITS-1:0] ring_len;

    case ($urandom_range(0, 7))
      0:       weight = 0;
      1:       weight = 65536;
      2:       weight = $urandom_range(65537, 131071);
      3:       weight = $urandom_range(1, 65535);
      default: weight = $urandom_range(300, 8000);
    endcase
    case ($urandom_range(0, 5))
      0:       threshold = 0;
      1:       threshold = 4095;
      default: threshold = $urandom_range(1, 400);
    endcase
    case ($urandom_range(0, 5))
      0:       margin = 0;
      1:       margin = 4095;
      default: margin = $urandom_range(0, 400);
    endcase
    case ($urandom_range(0, 6))
      0:       ring_len = 0;
      1:       ring_len = 1;
      2:       ring_len = 2;
      3:       ring_len = 1024;
      4:       ring_len = $urandom_range(1025, 2047);
      default: ring_len = $urandom_range(3, 64);
    endcase
    if (long_ring) begin
      weight    = 655;
      threshold = $urandom_range(100, 400);
      margin    = $urandom_range(0, 100);
      ring_len  = 1024;
    end

    write_register(REG_SMOOTHING_WEIGHT, weight);
    write_register(REG_DIP_THRESHOLD, threshold);
    write_register(REG_RELEASE_MARGIN, margin);
    write_register(REG_HISTORY_LENGTH, ring_len);

    for (int n = 0; n < count; n++) begin
      if (n == count / 2)
        wait_for_results();
      next_random_request(op, smp, idx);
      send_request(op, smp, idx);
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_seed_and_dip();
    test_weight_extremes();
    test_threshold_and_margin();
    test_history_length();

    // Sender idles lightly, receiver heavily.
    tx_idle_pct = 19;
    rx_idle_pct = 59;
    test_backpressure();
    repeat (3) test_random_phase(45, 1'b0);

    // The other way round.
    tx_idle_pct = 59;
    rx_idle_pct = 19;
    repeat (3) test_random_phase(45, 1'b0);

    // No idling at all, on the full-length ring.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_phase(530, 1'b1);

    while (pending_readouts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
